[rtl/imu_ring_interpolate_blend_core_macros.svh]
// assertion macros for the rtl, included by irib_exec
`ifndef IMU_RING_INTERPOLATE_BLEND_CORE_MACROS_SVH
`define IMU_RING_INTERPOLATE_BLEND_CORE_MACROS_SVH

// implication in the same cycle
`define IRIB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("irib assertion failed");

// implication in the next cycle
`define IRIB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("irib assertion failed");

`endif

[rtl/irib_pkg.sv]
package irib_pkg;

    localparam int TIME_W    = 48;
    localparam int TARGET_W  = TIME_W + 1;
    localparam int ANGLE_W   = 16;
    localparam int PERIOD_W  = 20;
    localparam int FRAC_BITS = 15;
    localparam int MAG_W     = TARGET_W;
    localparam int DEN_W     = TIME_W;
    localparam int DVD_W     = MAG_W + FRAC_BITS;
    localparam int QUOT_W    = 32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;

    localparam logic [PERIOD_W-1:0] SCAN_PERIOD_RESET = 20'd100000;

    localparam logic CMD_STORE  = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    typedef struct packed {
        logic                      cmd;
        logic [TIME_W-1:0]         event_time;
        logic signed [ANGLE_W-1:0] sample_roll;
        logic signed [ANGLE_W-1:0] sample_pitch;
        logic signed [ANGLE_W-1:0] est_pitch;
        logic signed [ANGLE_W-1:0] est_roll;
    } t_in_item;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] fused_pitch;
        logic signed [ANGLE_W-1:0] fused_roll;
        logic                      imu_applied;
        logic                      interpolated;
    } t_out_item;

    // store: time is the sample time; update: time is scan time plus period
    typedef struct packed {
        logic                      is_update;
        logic [TARGET_W-1:0]       time_val;
        logic signed [ANGLE_W-1:0] ang_pitch;
        logic signed [ANGLE_W-1:0] ang_roll;
    } t_queue_entry;

    typedef struct packed {
        logic         valid;
        t_queue_entry entry;
    } t_queue_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] mag;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_div_rsp;

endpackage

[rtl/irib_front.sv]
module irib_front
    import irib_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [PERIOD_W-1:0] i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in_item            i_in_data,
    input  t_queue_status       i_q_stat,
    output t_queue_push         o_push
);

    logic [PERIOD_W-1:0] r_scan_period;
    logic [PERIOD_W-1:0] n_scan_period;

    always_comb begin
        n_scan_period = r_scan_period;
        if (i_cfg_we) begin
            n_scan_period = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_period <= SCAN_PERIOD_RESET;
        end else begin
            r_scan_period <= n_scan_period;
        end
    end

    assign o_in_ready = !i_q_stat.full;

    always_comb begin
        o_push.valid = i_in_valid && !i_q_stat.full;
        if (i_in_data.cmd == CMD_UPDATE) begin
            o_push.entry.is_update = 1'b1;
            o_push.entry.time_val  = {1'b0, i_in_data.event_time}
                                   + TARGET_W'(r_scan_period);
            o_push.entry.ang_pitch = i_in_data.est_pitch;
            o_push.entry.ang_roll  = i_in_data.est_roll;
        end else begin
            o_push.entry.is_update = 1'b0;
            o_push.entry.time_val  = {1'b0, i_in_data.event_time};
            o_push.entry.ang_pitch = i_in_data.sample_pitch;
            o_push.entry.ang_roll  = i_in_data.sample_roll;
        end
    end

endmodule

[rtl/irib_fifo.sv]
module irib_fifo
    import irib_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_queue_push   i_push,
    input  logic          i_pop,
    output t_queue_status o_stat,
    output t_queue_entry  o_head
);

    t_queue_entry            r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]     r_wr_ptr;
    logic [QUEUE_AW-1:0]     r_rd_ptr;
    logic [QUEUE_AW:0]       r_count;
    logic [QUEUE_AW-1:0]     n_wr_ptr;
    logic [QUEUE_AW-1:0]     n_rd_ptr;
    logic [QUEUE_AW:0]       n_count;
    logic                    do_push;
    logic                    do_pop;

    assign o_stat.full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_head       = r_mem[r_rd_ptr];

    assign do_push = i_push.valid && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!do_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.entry;
        end
    end

endmodule

[rtl/irib_div.sv]
module irib_div
    import irib_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int                STEP_W    = $clog2(DVD_W);
    localparam logic [QUOT_W-1:0] QUOT_SAT  = QUOT_W'(1) << (QUOT_W - 1);

    logic [DEN_W-1:0]  r_rem;
    logic [DVD_W-1:0]  r_dvd;
    logic [DEN_W-1:0]  r_den;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DEN_W-1:0]  n_rem;
    logic [DVD_W-1:0]  n_dvd;
    logic [DEN_W-1:0]  n_den;
    logic [STEP_W-1:0] n_cnt;
    logic              n_busy;
    logic              n_done;
    logic [DEN_W:0]    rem_sh;
    logic [DEN_W:0]    rem_sub;
    logic              ge;
    logic              sat;

    assign rem_sh  = {r_rem, r_dvd[DVD_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign ge      = (rem_sh >= {1'b0, r_den});

    always_comb begin
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_dvd  = {i_req.mag, FRAC_BITS'(0)};
            n_den  = i_req.den;
        end else if (r_busy) begin
            n_rem = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            n_dvd = {r_dvd[DVD_W-2:0], ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == STEP_W'(DVD_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_den <= n_den;
    end

    // integer parts of 2^16 or more saturate the interpolated angle anyway
    assign sat        = |r_dvd[DVD_W-1:QUOT_W-1];
    assign o_rsp.done = r_done;
    assign o_rsp.quot = sat ? QUOT_SAT : r_dvd[QUOT_W-1:0];

endmodule

[rtl/irib_exec.sv]
module irib_exec
    import irib_pkg::*;
#(
    parameter int RING_DEPTH = 256
)
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_queue_status i_q_stat,
    input  t_queue_entry  i_q_head,
    output logic          o_pop,
    output t_div_req      o_div_req,
    input  t_div_rsp      i_div_rsp,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output t_out_item     o_out_data
);

    `include "imu_ring_interpolate_blend_core_macros.svh"

    localparam int                SLOT_W = $clog2(RING_DEPTH);
    localparam logic [SLOT_W-1:0] LAST   = SLOT_W'(RING_DEPTH - 1);
    localparam int                PROD_W = ANGLE_W + QUOT_W;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_WCHK  = 8'b0000_0010,
        S_BCHK  = 8'b0000_0100,
        S_DIV   = 8'b0000_1000,
        S_MUL   = 8'b0001_0000,
        S_INTP  = 8'b0010_0000,
        S_BLEND = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_exec_state;

    typedef struct packed {
        logic [TIME_W-1:0]         time_val;
        logic signed [ANGLE_W-1:0] roll;
        logic signed [ANGLE_W-1:0] pitch;
    } t_ring_word;

    function automatic logic signed [ANGLE_W-1:0] sat16(input logic signed [34:0] v);
        logic signed [ANGLE_W-1:0] res;
        if (v > 35'sd32767) begin
            res = 16'sh7fff;
        end else if (v < -35'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = v[ANGLE_W-1:0];
        end
        return res;
    endfunction

    t_ring_word r_ring [RING_DEPTH];

    t_exec_state               r_state, n_state;
    logic [SLOT_W-1:0]         r_ws, n_ws;
    logic [SLOT_W-1:0]         r_rs, n_rs;
    logic                      r_have, n_have;
    logic                      r_full, n_full;
    logic                      r_ch, n_ch;
    logic [TARGET_W-1:0]       r_target, n_target;
    logic signed [ANGLE_W-1:0] r_est [2];
    logic signed [ANGLE_W-1:0] n_est [2];
    logic signed [ANGLE_W-1:0] r_front [2];
    logic signed [ANGLE_W-1:0] n_front [2];
    logic signed [ANGLE_W-1:0] r_back [2];
    logic signed [ANGLE_W-1:0] n_back [2];
    logic signed [ANGLE_W-1:0] r_imu [2];
    logic signed [ANGLE_W-1:0] n_imu [2];
    logic signed [ANGLE_W-1:0] r_fused [2];
    logic signed [ANGLE_W-1:0] n_fused [2];
    logic [TIME_W-1:0]         r_tf, n_tf;
    logic                      r_neg, n_neg;
    logic [QUOT_W-1:0]         r_q, n_q;
    logic [PROD_W-1:0]         r_prod, n_prod;
    logic                      r_psign, n_psign;
    logic                      r_applied, n_applied;
    logic                      r_interp, n_interp;
    logic                      r_out_valid, n_out_valid;
    t_out_item                 r_out, n_out;

    t_ring_word        r_rd_word;
    logic              r_rd_ok;
    logic [SLOT_W-1:0] rd_addr;
    logic              ring_we;
    logic [SLOT_W-1:0] ws_inc;
    logic [SLOT_W-1:0] rs_inc;
    logic [SLOT_W-1:0] rs_dec;
    logic              addr_ok;

    logic [TIME_W-1:0]         rd_time;
    logic signed [ANGLE_W-1:0] rd_roll;
    logic signed [ANGLE_W-1:0] rd_pitch;
    logic [TARGET_W-1:0]       rd_time_x;
    logic                      walk_adv;

    logic signed [ANGLE_W:0]   diff;
    logic [ANGLE_W:0]          diff_neg;
    logic [ANGLE_W-1:0]        diff_abs;
    logic [PROD_W-1:0]         prod;
    logic signed [PROD_W:0]    sprod;
    logic signed [PROD_W:0]    rnd;
    logic signed [34:0]        isum;
    logic signed [33:0]        acc;

    assign ws_inc = (r_ws == LAST) ? '0 : r_ws + 1'b1;
    assign rs_inc = (r_rs == LAST) ? '0 : r_rs + 1'b1;
    assign rs_dec = (r_rs == '0) ? LAST : r_rs - 1'b1;

    // slots past the fill count read as zero
    assign addr_ok = r_have && (r_full || (rd_addr <= r_ws));

    assign rd_time   = r_rd_ok ? r_rd_word.time_val : '0;
    assign rd_roll   = r_rd_ok ? r_rd_word.roll : '0;
    assign rd_pitch  = r_rd_ok ? r_rd_word.pitch : '0;
    assign rd_time_x = {1'b0, rd_time};
    assign walk_adv  = (r_rs != r_ws) && !(r_target < rd_time_x);

    assign diff     = $signed({r_front[r_ch][ANGLE_W-1], r_front[r_ch]})
                    - $signed({r_back[r_ch][ANGLE_W-1], r_back[r_ch]});
    assign diff_neg = -diff;
    assign diff_abs = diff[ANGLE_W] ? diff_neg[ANGLE_W-1:0] : diff[ANGLE_W-1:0];
    assign prod     = diff_abs * r_q;

    assign sprod = r_psign ? -$signed({1'b0, r_prod}) : $signed({1'b0, r_prod});
    assign rnd   = sprod + $signed((PROD_W+1)'(1) <<< (FRAC_BITS - 1));
    assign isum  = $signed({rnd[PROD_W], rnd[PROD_W:FRAC_BITS]})
                 + $signed({{19{r_back[r_ch][ANGLE_W-1]}}, r_back[r_ch]});

    assign acc = $signed({{18{r_est[r_ch][ANGLE_W-1]}}, r_est[r_ch]}) * 34'sd65405
               + $signed({{18{r_imu[r_ch][ANGLE_W-1]}}, r_imu[r_ch]}) * 34'sd131
               + 34'sd32768;

    always_comb begin
        n_state     = r_state;
        n_ws        = r_ws;
        n_rs        = r_rs;
        n_have      = r_have;
        n_full      = r_full;
        n_ch        = r_ch;
        n_target    = r_target;
        n_est       = r_est;
        n_front     = r_front;
        n_back      = r_back;
        n_imu       = r_imu;
        n_fused     = r_fused;
        n_tf        = r_tf;
        n_neg       = r_neg;
        n_q         = r_q;
        n_prod      = r_prod;
        n_psign     = r_psign;
        n_applied   = r_applied;
        n_interp    = r_interp;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        ring_we     = 1'b0;
        rd_addr     = r_rs;
        o_pop       = 1'b0;
        o_div_req   = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop = 1'b1;
                    if (!i_q_head.is_update) begin
                        ring_we = 1'b1;
                        n_ws    = ws_inc;
                        n_have  = 1'b1;
                        if (ws_inc == LAST) begin
                            n_full = 1'b1;
                        end
                    end else begin
                        n_target   = i_q_head.time_val;
                        n_est[0]   = i_q_head.ang_pitch;
                        n_est[1]   = i_q_head.ang_roll;
                        n_interp   = 1'b0;
                        n_applied  = r_have;
                        if (r_have) begin
                            n_state = S_WCHK;
                        end else begin
                            n_fused[0] = i_q_head.ang_pitch;
                            n_fused[1] = i_q_head.ang_roll;
                            n_state    = S_DONE;
                        end
                    end
                end
            end
            S_WCHK: begin
                if (walk_adv) begin
                    n_rs    = rs_inc;
                    rd_addr = rs_inc;
                end else begin
                    n_tf       = rd_time;
                    n_front[0] = rd_pitch;
                    n_front[1] = rd_roll;
                    n_imu[0]   = rd_pitch;
                    n_imu[1]   = rd_roll;
                    if (r_target > rd_time_x) begin
                        n_state = S_BLEND;
                    end else begin
                        rd_addr = rs_dec;
                        n_state = S_BCHK;
                    end
                end
            end
            S_BCHK: begin
                if (r_tf > rd_time) begin
                    n_back[0]       = rd_pitch;
                    n_back[1]       = rd_roll;
                    n_interp        = 1'b1;
                    o_div_req.start = 1'b1;
                    o_div_req.den   = r_tf - rd_time;
                    if (r_target >= rd_time_x) begin
                        o_div_req.mag = r_target - rd_time_x;
                        n_neg         = 1'b0;
                    end else begin
                        o_div_req.mag = rd_time_x - r_target;
                        n_neg         = 1'b1;
                    end
                    n_state = S_DIV;
                end else begin
                    n_state = S_BLEND;
                end
            end
            S_DIV: begin
                if (i_div_rsp.done) begin
                    n_q     = i_div_rsp.quot;
                    n_ch    = 1'b0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = prod;
                n_psign = diff[ANGLE_W] ^ r_neg;
                n_state = S_INTP;
            end
            S_INTP: begin
                n_imu[r_ch] = sat16(isum);
                if (!r_ch) begin
                    n_ch    = 1'b1;
                    n_state = S_MUL;
                end else begin
                    n_ch    = 1'b0;
                    n_state = S_BLEND;
                end
            end
            S_BLEND: begin
                n_fused[r_ch] = sat16($signed({{17{acc[33]}}, acc[33:16]}));
                if (!r_ch) begin
                    n_ch = 1'b1;
                end else begin
                    n_ch    = 1'b0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid        = 1'b1;
                    n_out.fused_pitch  = r_fused[0];
                    n_out.fused_roll   = r_fused[1];
                    n_out.imu_applied  = r_applied;
                    n_out.interpolated = r_interp;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ws        <= LAST;
            r_rs        <= '0;
            r_have      <= 1'b0;
            r_full      <= 1'b0;
            r_ch        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ws        <= n_ws;
            r_rs        <= n_rs;
            r_have      <= n_have;
            r_full      <= n_full;
            r_ch        <= n_ch;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_target  <= n_target;
        r_est     <= n_est;
        r_front   <= n_front;
        r_back    <= n_back;
        r_imu     <= n_imu;
        r_fused   <= n_fused;
        r_tf      <= n_tf;
        r_neg     <= n_neg;
        r_q       <= n_q;
        r_prod    <= n_prod;
        r_psign   <= n_psign;
        r_applied <= n_applied;
        r_interp  <= n_interp;
        r_out     <= n_out;
    end

    // ring memory, one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[ws_inc] <= '{time_val: i_q_head.time_val[TIME_W-1:0],
                                roll:     i_q_head.ang_roll,
                                pitch:    i_q_head.ang_pitch};
        end
        r_rd_word <= r_ring[rd_addr];
        r_rd_ok   <= addr_ok;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `IRIB_ASSERT_NOW(a_div_den_nonzero, i_clk, i_rst_n,
        o_div_req.start, o_div_req.den != '0)
    `IRIB_ASSERT_NOW(a_div_done_in_div, i_clk, i_rst_n,
        i_div_rsp.done, r_state == S_DIV)
    `IRIB_ASSERT_NOW(a_interp_needs_imu, i_clk, i_rst_n,
        r_out_valid, !r_out.interpolated || r_out.imu_applied)
    `IRIB_ASSERT_NOW(a_result_from_done, i_clk, i_rst_n,
        $rose(r_out_valid), $past(r_state == S_DONE))

endmodule

[rtl/imu_ring_interpolate_blend_core.sv]
// store transaction: written to the ring; the queue takes one per cycle unless full
// update transaction: walks the ring slots, then interpolates using the 64-step
//   restoring divider; one update in the back end at a time
// update without interpolation: walk, optional back-slot check, then blend;
//   no stored sample: the estimate is output as is; a stalled output delays the result
// reset: synchronous active low; ring is not swept, slots beyond the fill count
//   read as zero, scan period returns to 100000, ready is high once the queue is reset
module imu_ring_interpolate_blend_core
    import irib_pkg::*;
#(
    parameter int RING_DEPTH = 256
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [PERIOD_W-1:0] i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in_item            i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_item           o_out_data
);

    t_queue_push   q_push;
    t_queue_status q_stat;
    t_queue_entry  q_head;
    logic          q_pop;
    t_div_req      div_req;
    t_div_rsp      div_rsp;

    irib_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_stat   (q_stat),
        .o_push     (q_push)
    );

    irib_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_pop   (q_pop),
        .o_stat  (q_stat),
        .o_head  (q_head)
    );

    irib_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    irib_exec #(
        .RING_DEPTH (RING_DEPTH)
    ) u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (q_stat),
        .i_q_head    (q_head),
        .o_pop       (q_pop),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
